FILE: rtl/core/sfr_pkg.sv
`default_nettype none

package sfr_pkg;

  // Frame framing constants
  localparam logic [7:0] PREAMBLE_BYTE = 8'hAA;
  localparam logic [3:0] TYPE_REQUEST  = 4'h1;
  localparam logic [3:0] TYPE_RESPONSE = 4'h2;

  // Packed output word width: field_number plus four data bytes, padded to bytes
  localparam int unsigned OUT_DATA_BITS = 40;

  typedef enum logic [1:0] {
    MODE_HUNT    = 2'd0,
    MODE_HEADER  = 2'd1,
    MODE_PAYLOAD = 2'd2,
    MODE_DISCARD = 2'd3
  } frame_mode_t;

  typedef struct packed {
    logic       field_valid;
    logic       frame_end;
    logic [1:0] field_number;
    logic [7:0] sensor_id;
    logic [7:0] bus_address;
    logic [7:0] register_address;
    logic [7:0] register_value;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/sfr_parser.sv
`default_nettype none

module sfr_parser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire logic [7:0]      rx_byte,
  output sfr_pkg::result_t     result,
  output logic                 result_hit
);

  sfr_pkg::frame_mode_t mode_r, mode_nxt;
  logic [3:0] bytes_left_r, bytes_left_nxt;
  logic [1:0] byte_in_field_r, byte_in_field_nxt;
  logic [1:0] field_count_r, field_count_nxt;
  logic [7:0] held_id_r, held_id_nxt;
  logic [7:0] held_bus_r, held_bus_nxt;
  logic [7:0] held_reg_r, held_reg_nxt;

  logic [3:0] kind;
  logic [3:0] len;
  logic       last;

  assign kind = rx_byte[7:4];
  assign len  = rx_byte[3:0];
  assign last = (bytes_left_r <= 4'd1);

  // Next state and result for the current word
  always_comb begin
    mode_nxt          = mode_r;
    bytes_left_nxt    = bytes_left_r;
    byte_in_field_nxt = byte_in_field_r;
    field_count_nxt   = field_count_r;
    held_id_nxt       = held_id_r;
    held_bus_nxt      = held_bus_r;
    held_reg_nxt      = held_reg_r;
    result            = '0;
    result_hit        = 1'b0;

    case (mode_r)
      sfr_pkg::MODE_HUNT: begin
        if (rx_byte == sfr_pkg::PREAMBLE_BYTE) begin
          mode_nxt = sfr_pkg::MODE_HEADER;
        end
      end
      sfr_pkg::MODE_HEADER: begin
        byte_in_field_nxt = 2'd0;
        field_count_nxt   = 2'd0;
        bytes_left_nxt    = len;
        if (kind == sfr_pkg::TYPE_REQUEST) begin
          mode_nxt = sfr_pkg::MODE_DISCARD;
        end else if (kind == sfr_pkg::TYPE_RESPONSE && len != 4'd0) begin
          mode_nxt = sfr_pkg::MODE_PAYLOAD;
        end else begin
          mode_nxt = sfr_pkg::MODE_HUNT;
        end
      end
      sfr_pkg::MODE_PAYLOAD: begin
        // Collect bytes; the fourth completes a field
        case (byte_in_field_r)
          2'd0: held_id_nxt  = rx_byte;
          2'd1: held_bus_nxt = rx_byte;
          2'd2: held_reg_nxt = rx_byte;
          default: begin
            result_hit              = 1'b1;
            result.field_valid      = 1'b1;
            result.frame_end        = last;
            result.field_number     = field_count_r;
            result.sensor_id        = held_id_r;
            result.bus_address      = held_bus_r;
            result.register_address = held_reg_r;
            result.register_value   = rx_byte;
            field_count_nxt         = field_count_r + 2'd1;
          end
        endcase
        if (last) begin
          // Frame ends mid-field: flag end with no field
          if (byte_in_field_r != 2'd3) begin
            result_hit       = 1'b1;
            result.frame_end = 1'b1;
          end
          bytes_left_nxt    = 4'd0;
          byte_in_field_nxt = 2'd0;
          field_count_nxt   = 2'd0;
          mode_nxt          = sfr_pkg::MODE_HUNT;
        end else begin
          bytes_left_nxt    = bytes_left_r - 4'd1;
          byte_in_field_nxt = byte_in_field_r + 2'd1;
        end
      end
      default: begin
        mode_nxt = sfr_pkg::MODE_HUNT;
      end
    endcase
  end

  // Advance state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= sfr_pkg::MODE_HUNT;
      bytes_left_r    <= 4'd0;
      byte_in_field_r <= 2'd0;
      field_count_r   <= 2'd0;
      held_id_r       <= 8'd0;
      held_bus_r      <= 8'd0;
      held_reg_r      <= 8'd0;
    end else if (accept) begin
      mode_r          <= mode_nxt;
      bytes_left_r    <= bytes_left_nxt;
      byte_in_field_r <= byte_in_field_nxt;
      field_count_r   <= field_count_nxt;
      held_id_r       <= held_id_nxt;
      held_bus_r      <= held_bus_nxt;
      held_reg_r      <= held_reg_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sfr_out_reg.sv
`default_nettype none

module sfr_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire sfr_pkg::result_t  result,
  input  wire logic              take,
  output logic                   valid,
  output sfr_pkg::result_t       held
);

  logic             valid_r, valid_nxt;
  sfr_pkg::result_t data_r;

  // Fill on a new result, drain when the word is taken
  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign valid = valid_r;
  assign held  = data_r;

endmodule

`default_nettype wire

FILE: rtl/core/sensor_frame_receiver_core.sv
// Sensor frame receiver.
// Input stream: one received serial byte per word on in_tdata. The block hunts
// for the preamble, reads the header (type in the high nibble, payload length
// in the low nibble) and groups response payloads into four-byte datafields.
// Output stream: one word per completed datafield, or an end marker with
// field_valid low when a frame ends mid-field. out_tlast marks the word made
// by the last payload byte of the frame; out_tuser carries field_valid.
// Timing: a result is registered and appears on the output in the cycle after
// the byte that makes it is accepted. Throughput: one byte per cycle while
// in_tready is high; the parser state update feeds one output register.
// Stall: in_tready stays high while the output register is empty or being
// taken in the same cycle; a stalled out_tready holds the word and blocks
// new bytes only while that word is waiting.
// Reset (rst_n low, synchronous): parser returns to preamble hunt and the
// output register is emptied.
`default_nettype none

module sensor_frame_receiver_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [7:0]                        in_tdata,   // [7:0] rx_byte
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [1:0] field_number, [9:2] sensor_id, [17:10] bus_address,
  // [25:18] register_address, [33:26] register_value, [39:34] zero
  output logic [sfr_pkg::OUT_DATA_BITS-1:0]      out_tdata,
  output logic                                   out_tlast,  // frame_end
  output logic [0:0]                             out_tuser   // [0] field_valid
);

  logic             accept;
  logic             take;
  logic             result_hit;
  sfr_pkg::result_t result;
  sfr_pkg::result_t held;

  assign take      = out_tvalid & out_tready;
  assign in_tready = !out_tvalid || out_tready;
  assign accept    = in_tvalid & in_tready;

  sfr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .rx_byte    (in_tdata),
    .result     (result),
    .result_hit (result_hit)
  );

  sfr_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (accept & result_hit),
    .result (result),
    .take   (take),
    .valid  (out_tvalid),
    .held   (held)
  );

  // Pack the held result onto the stream word
  assign out_tdata    = {6'd0, held.register_value, held.register_address,
                         held.bus_address, held.sensor_id, held.field_number};
  assign out_tlast    = held.frame_end;
  assign out_tuser[0] = held.field_valid;

endmodule

`default_nettype wire
